/* rtl/core/umpgw_pkg.sv */
// Shared types, constants and helper functions for the UMP group window router.
// Used by the front, queue, back and top-level modules; depends on nothing else.
package umpgw_pkg;

  localparam int MAX_SLOT_COUNT    = 4;
  localparam int HOST_DEVICE_COUNT = 4;
  localparam int QUEUE_DEPTH       = 2;
  localparam int QPTR_W            = $clog2(QUEUE_DEPTH);

  localparam logic [31:0] GROUP_CLEAR_MASK = 32'hF0FF_FFFF;

  // Message types that are never forwarded from the host side.
  localparam logic [3:0] MT_UTILITY    = 4'h0;
  localparam logic [3:0] MT_RESERVED_E = 4'hE;
  localparam logic [3:0] MT_STREAM     = 4'hF;

  typedef enum logic [1:0] {
    DEST_PC     = 2'd0,
    DEST_HOST   = 2'd1,
    DEST_BRIDGE = 2'd2
  } dest_t;

  typedef enum logic [2:0] {
    REG_SLOT_COUNT      = 3'd0,
    REG_GROUPS_PER_SLOT = 3'd1,
    REG_SLOT_ACTIVE     = 3'd2,
    REG_SLOT_HOST_VALID = 3'd3,
    REG_SLOT_HOST_INDEX = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [2:0] slot_count;
    logic [4:0] groups_per_slot;
    logic [3:0] slot_active_mask;
    logic [3:0] slot_host_valid_mask;
    logic [7:0] slot_host_index;
  } cfg_t;

  // One routed packet waiting to be sent.
  typedef struct packed {
    logic [3:0][31:0] words;
    logic [1:0]       last_idx;
    dest_t            dest;
    logic [1:0]       host;
  } pkt_t;

  // Packet length in words by message type.
  localparam logic [2:0] LEN_BY_TYPE [16] = '{
    3'd1, 3'd1, 3'd1, 3'd2,
    3'd2, 3'd4, 3'd1, 3'd1,
    3'd2, 3'd2, 3'd2, 3'd3,
    3'd3, 3'd4, 3'd4, 3'd4
  };

  typedef struct packed {
    logic [3:0] quo;
    logic [4:0] rem;
  } divmod_t;

  // Four-step restoring division of a group nibble by a window width of 1 to 16.
  function automatic divmod_t group_divmod(input logic [3:0] grp, input logic [4:0] width);
    divmod_t    res;
    logic [4:0] r;
    res = '0;
    r   = '0;
    for (int i = 3; i >= 0; i--) begin
      r = {r[3:0], grp[i]};
      if (r >= width) begin
        r = r - width;
        res.quo[i] = 1'b1;
      end
    end
    res.rem = r;
    return res;
  endfunction

endpackage

/* rtl/core/umpgw_front.sv */
// Front end: gathers packet words, decides the route and rewrites the group.
// Depends on umpgw_pkg; pushes routed packets into umpgw_queue.
module umpgw_front
  import umpgw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        accept,
  input  logic        op,
  input  logic [1:0]  source_host,
  input  logic [31:0] ump_word,
  input  logic        buffer_end,
  output logic        push,
  output pkt_t        push_pkt
);

  logic [1:0]  held;
  logic [2:0]  expected;
  logic [31:0] store [0:2];

  logic [2:0]  exp_now;
  logic [2:0]  count;
  logic        complete;
  logic [31:0] word0;
  logic [3:0]  mt;
  logic [3:0]  grp;
  logic [4:0]  gwin;
  logic [2:0]  nslots;
  divmod_t     dm;
  logic        drop;
  logic        forwardable;
  logic        host_found;
  logic [1:0]  host_slot;
  logic [6:0]  pc_grp_sum;
  logic [1:0]  q_host;
  logic        q_in_use;

  function automatic logic [1:0] host_of(input logic [7:0] idx, input logic [1:0] slot);
    return idx[2*slot +: 2];
  endfunction

  always_comb begin
    exp_now  = (held == 2'd0) ? LEN_BY_TYPE[ump_word[31:28]] : expected;
    count    = {1'b0, held} + 3'd1;
    complete = (count >= exp_now);
    word0    = (held == 2'd0) ? ump_word : store[0];
    mt       = word0[31:28];
    grp      = word0[27:24];

    if (cfg.groups_per_slot == 5'd0) begin
      gwin = 5'd1;
    end else if (cfg.groups_per_slot > 5'd16) begin
      gwin = 5'd16;
    end else begin
      gwin = cfg.groups_per_slot;
    end
    nslots = (int'(cfg.slot_count) > MAX_SLOT_COUNT) ? 3'(MAX_SLOT_COUNT) : cfg.slot_count;
    dm = group_divmod(grp, gwin);
    forwardable = (mt != MT_UTILITY) && (mt != MT_RESERVED_E) && (mt != MT_STREAM);

    // Lowest slot in use that maps the source host device.
    host_found = 1'b0;
    host_slot  = 2'd0;
    for (int s = 3; s >= 0; s--) begin
      if ((3'(s) < nslots) && cfg.slot_host_valid_mask[s] &&
          (host_of(cfg.slot_host_index, 2'(s)) == source_host)) begin
        host_found = 1'b1;
        host_slot  = 2'(s);
      end
    end
    pc_grp_sum = 7'(host_slot) * 7'(gwin) + 7'(dm.rem);

    q_in_use = forwardable && (dm.quo < 4'(nslots)) && (dm.quo < 4'd4) &&
               cfg.slot_active_mask[dm.quo[1:0]];
    q_host   = host_of(cfg.slot_host_index, dm.quo[1:0]);

    push_pkt          = '0;
    push_pkt.last_idx = 2'(exp_now - 3'd1);
    for (int k = 0; k < 3; k++) begin
      if (2'(k) != held) begin
        push_pkt.words[k] = store[k];
      end else begin
        push_pkt.words[k] = ump_word;
      end
    end
    push_pkt.words[3] = ump_word;

    drop = 1'b0;
    if (!op) begin
      drop = !forwardable || !host_found || (int'(source_host) >= HOST_DEVICE_COUNT);
      push_pkt.dest     = DEST_PC;
      push_pkt.words[0] = (word0 & GROUP_CLEAR_MASK) | {4'h0, pc_grp_sum[3:0], 24'h0};
    end else if (q_in_use) begin
      drop = !cfg.slot_host_valid_mask[dm.quo[1:0]] || (int'(q_host) >= HOST_DEVICE_COUNT);
      push_pkt.dest     = DEST_HOST;
      push_pkt.host     = q_host;
      push_pkt.words[0] = (word0 & GROUP_CLEAR_MASK) | {4'h0, dm.rem[3:0], 24'h0};
    end else begin
      push_pkt.dest     = DEST_BRIDGE;
      push_pkt.words[0] = word0;
    end

    push = accept && complete && !drop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held     <= 2'd0;
      expected <= 3'd0;
    end else if (accept) begin
      expected <= exp_now;
      if (complete || buffer_end) begin
        held <= 2'd0;
      end else begin
        held <= held + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !complete) begin
      store[held] <= ump_word;
    end
  end

endmodule

/* rtl/core/umpgw_queue.sv */
// Short packet queue between the front end and the back end.
// Depends on umpgw_pkg for the packet type and depth.
module umpgw_queue
  import umpgw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  pkt_t push_pkt,
  input  logic pop,
  output pkt_t head,
  output logic empty,
  output logic full
);

  pkt_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign empty = (fill == '0);
  assign full  = (fill == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_pkt;
    end
  end

endmodule

/* rtl/core/umpgw_back.sv */
// Back end: takes routed packets from the queue and sends them a word at a time.
// Depends on umpgw_pkg for the packet and destination types.
module umpgw_back
  import umpgw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  pkt_t        q_head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_word,
  output dest_t       out_dest,
  output logic [1:0]  out_host,
  output logic        out_last
);

  pkt_t       cur;
  logic       busy;
  logic [1:0] k;
  logic       fire;

  always_comb begin
    fire      = busy && out_ready;
    out_last  = (k == cur.last_idx);
    pop       = !q_empty && (!busy || (fire && out_last));
    out_valid = busy;
    out_word  = cur.words[k];
    out_dest  = cur.dest;
    out_host  = cur.host;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      k    <= 2'd0;
    end else if (pop) begin
      busy <= 1'b1;
      k    <= 2'd0;
    end else if (fire) begin
      if (out_last) begin
        busy <= 1'b0;
      end else begin
        k <= k + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end
  end

endmodule

/* rtl/core/ump_group_window_router.sv */
// Top level of the UMP group window router: configuration registers and the
// front end, packet queue and back end. Depends on umpgw_pkg and the umpgw_* modules.
//
// Usage: 32-bit Universal MIDI Packet words enter on the s_axis channel, one word per
// transfer, with tuser telling whether the word came from a host device (and which one)
// or from the PC, and tlast marking the final word of a delivered buffer. The front end
// gathers a packet, whose length follows from the message type of its first word, and
// when the last word arrives it decides the route in the same cycle: to the PC with the
// group moved into the slot's window, to a host device with a local group, to the
// bridge endpoint, or nowhere. Routed packets wait in a two-entry packet queue and the
// back end sends them on m_axis, one word per transfer, with tlast on the final word.
// With the back end idle, a packet is written into the queue as its last input word is
// accepted; the back end then loads it and raises tvalid for its first word. Throughput:
// one word per cycle in while a queue entry is free, and one word per cycle out while
// packets wait and m_axis_tready is high; the input is held off only while both queue
// entries are occupied. Dropped and cut-short packets produce no output.
// Reset restores the default configuration, discards any partial packet and empties
// the queue. Configuration is written on the cfg channel, which is always ready, and
// should only be changed while no packet is in flight.
module ump_group_window_router
  import umpgw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input words.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // ump_word
  input  logic [2:0]  s_axis_tuser,   // op [0], source_host [2:1]
  input  logic        s_axis_tlast,   // buffer_end
  // Routed words.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_word
  output logic [3:0]  m_axis_tuser,   // destination [1:0], target_host [3:2]
  output logic        m_axis_tlast,   // packet_last
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  cfg_t       cfg;
  logic       in_accept;
  logic       push;
  pkt_t       push_pkt;
  logic       pop;
  pkt_t       q_head;
  logic       q_empty;
  logic       q_full;
  dest_t      out_dest;
  logic [1:0] out_host;

  // The queue is checked as a whole, so a completing word always finds a free entry.
  assign s_axis_tready = !q_full;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign m_axis_tuser  = {out_host, out_dest};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slot_count           <= 3'd4;
      cfg.groups_per_slot      <= 5'd4;
      cfg.slot_active_mask     <= 4'd0;
      cfg.slot_host_valid_mask <= 4'd0;
      cfg.slot_host_index      <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SLOT_COUNT:      cfg.slot_count           <= cfg_data[2:0];
        REG_GROUPS_PER_SLOT: cfg.groups_per_slot      <= cfg_data[4:0];
        REG_SLOT_ACTIVE:     cfg.slot_active_mask     <= cfg_data[3:0];
        REG_SLOT_HOST_VALID: cfg.slot_host_valid_mask <= cfg_data[3:0];
        REG_SLOT_HOST_INDEX: cfg.slot_host_index      <= cfg_data;
        default: ;
      endcase
    end
  end

  umpgw_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (in_accept),
    .op          (s_axis_tuser[0]),
    .source_host (s_axis_tuser[2:1]),
    .ump_word    (s_axis_tdata),
    .buffer_end  (s_axis_tlast),
    .push        (push),
    .push_pkt    (push_pkt)
  );

  umpgw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_pkt (push_pkt),
    .pop      (pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  umpgw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_word  (m_axis_tdata),
    .out_dest  (out_dest),
    .out_host  (out_host),
    .out_last  (m_axis_tlast)
  );

endmodule
